### hw/rtl/fen_position_parser_top_defines.svh
// Assertion helpers used by the RTL that carries checks.
`ifndef FEN_POSITION_PARSER_TOP_DEFINES_SVH
`define FEN_POSITION_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define FPP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpp check failed");

// Next-cycle implication, disabled while in reset.
`define FPP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpp check failed");

`endif

### hw/rtl/fpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpp_pkg;

   localparam int PIECE_COUNT         = 12;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [3:0] IDX_WHITE = 4'd12;
   localparam logic [3:0] IDX_BLACK = 4'd13;
   localparam logic [3:0] IDX_ALL   = 4'd14;

   localparam logic [7:0] CH_SLASH = "/";
   localparam logic [7:0] CH_SPACE = " ";
   localparam logic [7:0] CH_DASH  = "-";
   localparam logic [7:0] CH_W     = "w";
   localparam logic [7:0] CH_B     = "b";
   localparam logic [7:0] CH_WK    = "K";
   localparam logic [7:0] CH_WQ    = "Q";
   localparam logic [7:0] CH_BK    = "k";
   localparam logic [7:0] CH_BQ    = "q";
   localparam logic [7:0] CH_ONE   = "1";
   localparam logic [7:0] CH_EIGHT = "8";
   localparam logic [7:0] CH_A     = "a";
   localparam logic [7:0] CH_H     = "h";

   typedef enum logic [3:0] {
      PH_SKIP_WORD,
      PH_SKIP_SPACE,
      PH_PLACEMENT,
      PH_SIDE,
      PH_SIDE_GAP,
      PH_CASTLE,
      PH_EP,
      PH_EP_RANK,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [PIECE_COUNT-1:0][63:0] boards;
      logic                         white_to_move;
      logic [3:0]                   castle_rights;
      logic                         ep_valid;
      logic [2:0]                   ep_file;
      logic [2:0]                   ep_rank;
   } snap_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] slot;
   } slot_type;

   function automatic slot_type piece_slot(input logic [7:0] c);
      slot_type s;
      s.hit = 1'b1;
      case (c)
         "K": s.slot = 4'd0;
         "Q": s.slot = 4'd1;
         "R": s.slot = 4'd2;
         "B": s.slot = 4'd3;
         "N": s.slot = 4'd4;
         "P": s.slot = 4'd5;
         "k": s.slot = 4'd6;
         "q": s.slot = 4'd7;
         "r": s.slot = 4'd8;
         "b": s.slot = 4'd9;
         "n": s.slot = 4'd10;
         "p": s.slot = 4'd11;
         default: begin
            s.hit  = 1'b0;
            s.slot = 4'd0;
         end
      endcase
      return s;
   endfunction

   function automatic logic [3:0] sat_add(input logic [3:0] a, input logic [3:0] b);
      logic [4:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > 5'd15) ? 4'd15 : s[3:0];
   endfunction

endpackage

`default_nettype wire

### hw/rtl/fpp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fpp_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_char_in,
   input  wire logic                  req_end_of_string,
   input  wire fpp_pkg::q_status_type q_status,
   output logic                       push,
   output fpp_pkg::snap_type          snap
);
   import fpp_pkg::*;

   phase_type                    phase_ff, phase_in;
   logic [3:0]                   rank_ff, rank_in, rank_nx;
   logic [3:0]                   file_ff, file_in, file_nx;
   logic                         side_ff, side_in, side_nx;
   logic [3:0]                   castle_ff, castle_in, castle_nx;
   logic                         ep_flag_ff, ep_flag_in, ep_flag_nx;
   logic [5:0]                   ep_sq_ff, ep_sq_in, ep_sq_nx;
   logic [PIECE_COUNT-1:0][63:0] boards_ff, boards_in, boards_nx;

   logic       accept;
   logic       last;
   logic       is_space;
   logic       place_en;
   slot_type   slot;
   logic [5:0] square;
   logic [7:0] file_diff;
   logic [7:0] rank_diff;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign last      = accept && req_end_of_string;
   assign is_space  = (req_char_in == CH_SPACE);
   assign place_en  = accept && ((phase_ff == PH_PLACEMENT) ||
                                 ((phase_ff == PH_SKIP_SPACE) && !is_space));
   assign slot      = piece_slot(req_char_in);
   // top row of the string is rank 7 on the board
   assign square    = {~rank_ff[2:0], file_ff[2:0]};
   assign file_diff = req_char_in - CH_A;
   assign rank_diff = req_char_in - CH_ONE;

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_SKIP_WORD:  if (is_space) phase_in = PH_SKIP_SPACE;
            PH_SKIP_SPACE: if (!is_space) phase_in = PH_PLACEMENT;
            PH_PLACEMENT:  if (is_space) phase_in = PH_SIDE;
            PH_SIDE:       if (!is_space) phase_in = PH_SIDE_GAP;
            PH_SIDE_GAP:   phase_in = PH_CASTLE;
            PH_CASTLE:     if (is_space) phase_in = PH_EP;
            PH_EP: begin
               if (!is_space) begin
                  phase_in = (req_char_in == CH_DASH) ? PH_DONE : PH_EP_RANK;
               end
            end
            PH_EP_RANK:    phase_in = PH_DONE;
            PH_DONE:       phase_in = PH_DONE;
            default:       phase_in = PH_SKIP_WORD;
         endcase
         if (req_end_of_string) begin
            phase_in = PH_SKIP_WORD;
         end
      end
   end

   always_comb begin
      rank_nx   = rank_ff;
      file_nx   = file_ff;
      side_nx   = side_ff;
      castle_nx = castle_ff;
      ep_flag_nx = ep_flag_ff;
      ep_sq_nx  = ep_sq_ff;
      boards_nx = boards_ff;

      if (place_en && !is_space) begin
         priority if (req_char_in == CH_SLASH) begin
            rank_nx = sat_add(rank_ff, 4'd1);
            file_nx = 4'd0;
         end else if (req_char_in >= CH_ONE && req_char_in <= CH_EIGHT) begin
            file_nx = sat_add(file_ff, req_char_in[3:0]);
         end else begin
            // drop pieces that land off the board
            if (slot.hit && rank_ff < 4'd8 && file_ff < 4'd8) begin
               boards_nx[slot.slot][square] = 1'b1;
            end
            file_nx = sat_add(file_ff, 4'd1);
         end
      end

      if (accept && !is_space) begin
         unique case (phase_ff)
            PH_SIDE: begin
               if (req_char_in == CH_W) side_nx = 1'b1;
               if (req_char_in == CH_B) side_nx = 1'b0;
               castle_nx = 4'd0;
            end
            PH_CASTLE: begin
               if (req_char_in == CH_WK) castle_nx = castle_ff | 4'b0001;
               if (req_char_in == CH_WQ) castle_nx = castle_ff | 4'b0010;
               if (req_char_in == CH_BK) castle_nx = castle_ff | 4'b0100;
               if (req_char_in == CH_BQ) castle_nx = castle_ff | 4'b1000;
            end
            PH_EP: begin
               if (req_char_in == CH_DASH) begin
                  ep_flag_nx = 1'b0;
                  ep_sq_nx   = 6'd0;
               end else begin
                  ep_flag_nx = 1'b1;
                  ep_sq_nx   = {3'd7, (req_char_in >= CH_A && req_char_in <= CH_H) ?
                                      file_diff[2:0] : 3'd7};
               end
            end
            PH_EP_RANK: begin
               ep_sq_nx = {(req_char_in >= CH_ONE && req_char_in <= CH_EIGHT) ?
                              rank_diff[2:0] : 3'd7, ep_sq_ff[2:0]};
            end
            default: ;
         endcase
      end else if (accept && phase_ff == PH_EP_RANK) begin
         // a space is no rank digit
         ep_sq_nx = {3'd7, ep_sq_ff[2:0]};
      end
   end

   always_comb begin
      side_in = side_nx;
      if (last) begin
         rank_in    = 4'd0;
         file_in    = 4'd0;
         castle_in  = 4'd0;
         ep_flag_in = 1'b0;
         ep_sq_in   = 6'd0;
         boards_in  = '0;
      end else begin
         rank_in    = rank_nx;
         file_in    = file_nx;
         castle_in  = castle_nx;
         ep_flag_in = ep_flag_nx;
         ep_sq_in   = ep_sq_nx;
         boards_in  = boards_nx;
      end
   end

   assign push               = last;
   assign snap.boards        = boards_nx;
   assign snap.white_to_move = side_nx;
   assign snap.castle_rights = castle_nx;
   assign snap.ep_valid      = ep_flag_nx;
   assign snap.ep_file       = ep_flag_nx ? ep_sq_nx[2:0] : 3'd0;
   assign snap.ep_rank       = ep_flag_nx ? ep_sq_nx[5:3] : 3'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SKIP_WORD;
         rank_ff    <= 4'd0;
         file_ff    <= 4'd0;
         side_ff    <= 1'b1;
         castle_ff  <= 4'd0;
         ep_flag_ff <= 1'b0;
         ep_sq_ff   <= 6'd0;
         boards_ff  <= '0;
      end else begin
         phase_ff   <= phase_in;
         rank_ff    <= rank_in;
         file_ff    <= file_in;
         side_ff    <= side_in;
         castle_ff  <= castle_in;
         ep_flag_ff <= ep_flag_in;
         ep_sq_ff   <= ep_sq_in;
         boards_ff  <= boards_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/fpp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module fpp_queue #(
   parameter int DEPTH = fpp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire fpp_pkg::snap_type push_data,
   input  wire logic              pop,
   output fpp_pkg::snap_type      pop_data,
   output fpp_pkg::q_status_type  status
);
   import fpp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   snap_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign wr_ptr_in = push ? wrap_inc(wr_ptr_ff) : wr_ptr_ff;
   assign rd_ptr_in = pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/fpp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fpp_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fpp_pkg::snap_type     head,
   input  wire fpp_pkg::q_status_type q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [3:0]                 rsp_board_index,
   output logic [63:0]                rsp_board_value,
   output logic                       rsp_white_to_move,
   output logic [3:0]                 rsp_castle_rights,
   output logic                       rsp_ep_valid,
   output logic [2:0]                 rsp_ep_file,
   output logic [2:0]                 rsp_ep_rank,
   output logic                       rsp_last_board
);
   import fpp_pkg::*;

   logic [3:0]  index_ff, index_in;
   logic        valid_ff, valid_in;
   logic [3:0]  out_index_ff, out_index_in;
   logic [63:0] value_ff, value_in;
   logic        side_ff, side_in;
   logic [3:0]  castle_ff, castle_in;
   logic        ep_valid_ff, ep_valid_in;
   logic [2:0]  ep_file_ff, ep_file_in;
   logic [2:0]  ep_rank_ff, ep_rank_in;
   logic        last_ff, last_in;

   logic        load;
   logic        final_board;
   logic [63:0] white;
   logic [63:0] black;
   logic [63:0] sel;

   assign white = head.boards[0] | head.boards[1] | head.boards[2] |
                  head.boards[3] | head.boards[4] | head.boards[5];
   assign black = head.boards[6] | head.boards[7] | head.boards[8] |
                  head.boards[9] | head.boards[10] | head.boards[11];

   always_comb begin
      priority if (index_ff < 4'(PIECE_COUNT)) begin
         sel = head.boards[index_ff];
      end else if (index_ff == IDX_WHITE) begin
         sel = white;
      end else if (index_ff == IDX_BLACK) begin
         sel = black;
      end else begin
         sel = white | black;
      end
   end

   // refill the output register when it is empty or being taken
   assign load        = !q_status.empty && (!valid_ff || rsp_ready);
   assign final_board = (index_ff == IDX_ALL);
   assign pop         = load && final_board;

   always_comb begin
      index_in = index_ff;
      if (load) begin
         index_in = final_board ? 4'd0 : index_ff + 4'd1;
      end
      valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   end

   always_comb begin
      out_index_in = out_index_ff;
      value_in     = value_ff;
      side_in      = side_ff;
      castle_in    = castle_ff;
      ep_valid_in  = ep_valid_ff;
      ep_file_in   = ep_file_ff;
      ep_rank_in   = ep_rank_ff;
      last_in      = last_ff;
      if (load) begin
         out_index_in = index_ff;
         value_in     = sel;
         side_in      = head.white_to_move;
         castle_in    = head.castle_rights;
         ep_valid_in  = head.ep_valid;
         ep_file_in   = head.ep_file;
         ep_rank_in   = head.ep_rank;
         last_in      = final_board;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         index_ff <= index_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_index_ff <= out_index_in;
      value_ff     <= value_in;
      side_ff      <= side_in;
      castle_ff    <= castle_in;
      ep_valid_ff  <= ep_valid_in;
      ep_file_ff   <= ep_file_in;
      ep_rank_ff   <= ep_rank_in;
      last_ff      <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_board_index   = out_index_ff;
   assign rsp_board_value   = value_ff;
   assign rsp_white_to_move = side_ff;
   assign rsp_castle_rights = castle_ff;
   assign rsp_ep_valid      = ep_valid_ff;
   assign rsp_ep_file       = ep_file_ff;
   assign rsp_ep_rank       = ep_rank_ff;
   assign rsp_last_board    = last_ff;

endmodule

`default_nettype wire

### hw/rtl/fen_position_parser_top.sv
// Chess position string parser.
// Input channel (req_): one ASCII character per item, req_end_of_string set
// on the final character. The parser skips a leading word, reads the piece
// placement, side to move, castling letters and en passant square.
// Result channel (rsp_): fifteen items per string, boards 0-11 for the
// pieces, 12 all white, 13 all black, 14 all; rsp_last_board marks board 14.
// Side, castling and en passant fields repeat on every board.
// Throughput: one character per cycle while req_ready is high; the parser
// updates its state once per character. Results leave at one board per cycle
// while rsp_ready is high. The accepting edge of the last character writes
// the position into the queue; the output register loads its boards from there.
// A queue of QUEUE_DEPTH finished positions sits between parser and output;
// req_ready drops only while that queue is full, which happens when the
// receiver stalls or strings arrive faster than their fifteen boards leave.
// Reset clears all parser state, sets white to move and empties the queue.
// Side to move persists across strings unless a 'w' or 'b' is seen.
`timescale 1ns / 1ps
`default_nettype none

`include "fen_position_parser_top_defines.svh"

module fen_position_parser_top #(
   parameter int QUEUE_DEPTH = fpp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_in,
   input  wire logic        req_end_of_string,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_board_index,
   output logic [63:0]      rsp_board_value,
   output logic             rsp_white_to_move,
   output logic [3:0]       rsp_castle_rights,
   output logic             rsp_ep_valid,
   output logic [2:0]       rsp_ep_file,
   output logic [2:0]       rsp_ep_rank,
   output logic             rsp_last_board
);
   import fpp_pkg::*;

   q_status_type q_status;
   logic         push;
   logic         pop;
   snap_type     push_data;
   snap_type     head;

   fpp_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_in       (req_char_in),
      .req_end_of_string (req_end_of_string),
      .q_status          (q_status),
      .push              (push),
      .snap              (push_data)
   );

   fpp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (head),
      .status    (q_status)
   );

   fpp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .q_status          (q_status),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_board_index   (rsp_board_index),
      .rsp_board_value   (rsp_board_value),
      .rsp_white_to_move (rsp_white_to_move),
      .rsp_castle_rights (rsp_castle_rights),
      .rsp_ep_valid      (rsp_ep_valid),
      .rsp_ep_file       (rsp_ep_file),
      .rsp_ep_rank       (rsp_ep_rank),
      .rsp_last_board    (rsp_last_board)
   );

   `FPP_ASSERT_NEXT(a_board_sequence, clock, reset, rsp_valid && rsp_ready && !rsp_last_board, rsp_valid && (rsp_board_index == $past(rsp_board_index) + 4'd1))
   `FPP_ASSERT_SAME(a_last_is_all, clock, reset, rsp_valid, rsp_last_board == (rsp_board_index == IDX_ALL))
   `FPP_ASSERT_NEXT(a_string_queued, clock, reset, req_valid && req_ready && req_end_of_string, !q_status.empty)

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import fpp_pkg::*;

   typedef logic [7:0] char_t;

   typedef struct packed {
      logic [3:0]  index;
      logic [63:0] value;
      logic        wtm;
      logic [3:0]  castle;
      logic        ep_on;
      logic [2:0]  ep_file;
      logic [2:0]  ep_rank;
      logic        last;
   } board_rec_t;

   localparam string PIECE_LETTERS = "KQRBNPkqrbnp";

   localparam logic [3:0] CASTLE_WHITE_SHORT = 4'b0001;
   localparam logic [3:0] CASTLE_WHITE_LONG  = 4'b0010;
   localparam logic [3:0] CASTLE_BLACK_SHORT = 4'b0100;
   localparam logic [3:0] CASTLE_BLACK_LONG  = 4'b1000;

   // Position parser predictor plus the queue of boards it still owes.
   class board_scoreboard;
      logic [63:0] piece_bb [12];
      phase_type   phase;
      logic [3:0]  rank;
      logic [3:0]  file;
      logic        side;
      logic [3:0]  castle;
      logic        ep_on;
      logic [2:0]  ep_file;
      logic [2:0]  ep_rank;
      board_rec_t  owed_boards[$];
      int          errors;
      int          boards_seen;

      function new();
         clear_string();
         side        = 1'b1;
         errors      = 0;
         boards_seen = 0;
      endfunction

      function void clear_string();
         foreach (piece_bb[i]) piece_bb[i] = '0;
         phase   = PH_SKIP_WORD;
         rank    = '0;
         file    = '0;
         castle  = '0;
         ep_on   = 1'b0;
         ep_file = '0;
         ep_rank = '0;
      endfunction

      function logic [3:0] add_sat(logic [3:0] a, logic [3:0] b);
         int sum;
         sum = int'(a) + int'(b);
         return (sum > 15) ? 4'd15 : 4'(sum);
      endfunction

      function void place_char(char_t c);
         int slot;
         int sq;
         slot = -1;
         if (c == CH_SPACE) begin
            phase = PH_SIDE;
         end else if (c == CH_SLASH) begin
            rank = add_sat(rank, 4'd1);
            file = '0;
         end else if (c >= CH_ONE && c <= CH_EIGHT) begin
            file = add_sat(file, 4'(c - CH_ONE + 8'd1));
         end else begin
            for (int i = 0; i < 12; i++)
               if (char_t'(PIECE_LETTERS[i]) == c) slot = i;
            // drop pieces that land off the board
            if (slot >= 0 && rank < 4'd8 && file < 4'd8) begin
               sq = 8 * (7 - int'(rank)) + int'(file);
               piece_bb[slot][sq] = 1'b1;
            end
            file = add_sat(file, 4'd1);
         end
      endfunction

      function void parse_char(char_t c);
         case (phase)
            PH_SKIP_WORD: begin
               if (c == CH_SPACE) phase = PH_SKIP_SPACE;
            end
            PH_SKIP_SPACE: begin
               if (c != CH_SPACE) begin
                  phase = PH_PLACEMENT;
                  place_char(c);
               end
            end
            PH_PLACEMENT: place_char(c);
            PH_SIDE: begin
               if (c != CH_SPACE) begin
                  if (c == CH_W) side = 1'b1;
                  if (c == CH_B) side = 1'b0;
                  castle = '0;
                  phase  = PH_SIDE_GAP;
               end
            end
            PH_SIDE_GAP: phase = PH_CASTLE;
            PH_CASTLE: begin
               if (c == CH_SPACE) phase = PH_EP;
               else if (c == CH_WK) castle |= CASTLE_WHITE_SHORT;
               else if (c == CH_WQ) castle |= CASTLE_WHITE_LONG;
               else if (c == CH_BK) castle |= CASTLE_BLACK_SHORT;
               else if (c == CH_BQ) castle |= CASTLE_BLACK_LONG;
            end
            PH_EP: begin
               if (c == CH_DASH) begin
                  ep_on   = 1'b0;
                  ep_file = '0;
                  ep_rank = '0;
                  phase   = PH_DONE;
               end else if (c != CH_SPACE) begin
                  ep_on   = 1'b1;
                  ep_file = (c >= CH_A && c <= CH_H) ? 3'(c - CH_A) : 3'd7;
                  ep_rank = 3'd7;
                  phase   = PH_EP_RANK;
               end
            end
            PH_EP_RANK: begin
               ep_rank = (c >= CH_ONE && c <= CH_EIGHT) ? 3'(c - CH_ONE) : 3'd7;
               phase   = PH_DONE;
            end
            default: ;
         endcase
      endfunction

      function void note_char(char_t c, logic eos);
         logic [63:0] white;
         logic [63:0] black;
         board_rec_t  rec;
         parse_char(c);
         if (eos) begin
            white = '0;
            black = '0;
            for (int k = 0; k < 6; k++) begin
               white |= piece_bb[k];
               black |= piece_bb[k + 6];
            end
            for (int k = 0; k < 15; k++) begin
               rec.index   = 4'(k);
               if (k < 12) rec.value = piece_bb[k];
               else if (4'(k) == IDX_WHITE) rec.value = white;
               else if (4'(k) == IDX_BLACK) rec.value = black;
               else rec.value = white | black;
               rec.wtm     = side;
               rec.castle  = castle;
               rec.ep_on   = ep_on;
               rec.ep_file = ep_file;
               rec.ep_rank = ep_rank;
               rec.last    = (4'(k) == IDX_ALL);
               owed_boards.push_back(rec);
            end
            clear_string();
         end
      endfunction

      function void compare_field(string name, int idx, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("%0t: board %0d %s expected %0h actual %0h", $time, idx, name, want, got);
            errors++;
         end
      endfunction

      function void check_board(board_rec_t got);
         board_rec_t want;
         boards_seen++;
         if (owed_boards.size() == 0) begin
            $display("%0t: unexpected board %0d expected none actual %0h",
                     $time, got.index, got.value);
            errors++;
         end else begin
            want = owed_boards.pop_front();
            compare_field("index", want.index, want.index, got.index);
            compare_field("value", want.index, want.value, got.value);
            compare_field("white_to_move", want.index, want.wtm, got.wtm);
            compare_field("castle_rights", want.index, want.castle, got.castle);
            compare_field("ep_valid", want.index, want.ep_on, got.ep_on);
            compare_field("ep_file", want.index, want.ep_file, got.ep_file);
            compare_field("ep_rank", want.index, want.ep_rank, got.ep_rank);
            compare_field("last_board", want.index, want.last, got.last);
         end
      endfunction

      function int pending();
         return owed_boards.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_char_in;
   logic        req_end_of_string;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [3:0]  rsp_board_index;
   logic [63:0] rsp_board_value;
   logic        rsp_white_to_move;
   logic [3:0]  rsp_castle_rights;
   logic        rsp_ep_valid;
   logic [2:0]  rsp_ep_file;
   logic [2:0]  rsp_ep_rank;
   logic        rsp_last_board;

   board_scoreboard sb = new();
   char_t           line_buf[$];
   bit              calm = 1'b0;
   int              strings_sent = 0;
   int              chars_sent = 0;

   fen_position_parser_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_in       (req_char_in),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_board_index   (rsp_board_index),
      .rsp_board_value   (rsp_board_value),
      .rsp_white_to_move (rsp_white_to_move),
      .rsp_castle_rights (rsp_castle_rights),
      .rsp_ep_valid      (rsp_ep_valid),
      .rsp_ep_file       (rsp_ep_file),
      .rsp_ep_rank       (rsp_ep_rank),
      .rsp_last_board    (rsp_last_board)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic char_t any_but_space();
      char_t c;
      c = 8'($urandom_range(0, 255));
      if (c == CH_SPACE) c = 8'h7F;
      return c;
   endfunction

   function automatic void load_text(string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(char_t'(s[i]));
   endfunction

   // Build a mostly well-formed position string with random content.
   function automatic void make_position();
      char_t castle_pick[4];
      int    ranks;
      int    len;
      int    pick;
      castle_pick = '{CH_WK, CH_WQ, CH_BK, CH_BQ};
      line_buf.delete();
      repeat ($urandom_range(1, 3)) line_buf.push_back(8'(CH_A + $urandom_range(0, 25)));
      repeat ($urandom_range(1, 2)) line_buf.push_back(CH_SPACE);
      ranks = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 10) : $urandom_range(1, 8);
      for (int r = 0; r < ranks; r++) begin
         if (r > 0) line_buf.push_back(CH_SLASH);
         repeat ($urandom_range(1, 6)) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) line_buf.push_back(char_t'(PIECE_LETTERS[$urandom_range(0, 11)]));
            else if (pick < 9) line_buf.push_back(8'(CH_ONE + $urandom_range(0, 7)));
            else line_buf.push_back(any_but_space());
         end
      end
      repeat ($urandom_range(1, 2)) line_buf.push_back(CH_SPACE);
      pick = $urandom_range(0, 9);
      if (pick < 5) line_buf.push_back(CH_W);
      else if (pick < 9) line_buf.push_back(CH_B);
      else line_buf.push_back(any_but_space());
      line_buf.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : CH_SPACE);
      if ($urandom_range(0, 3) == 0) begin
         line_buf.push_back(CH_DASH);
      end else begin
         repeat ($urandom_range(1, 4)) line_buf.push_back(castle_pick[$urandom_range(0, 3)]);
         if ($urandom_range(0, 9) == 0) line_buf.push_back(any_but_space());
      end
      line_buf.push_back(CH_SPACE);
      if ($urandom_range(0, 1) == 0) begin
         line_buf.push_back(CH_DASH);
      end else begin
         line_buf.push_back(($urandom_range(0, 9) == 0) ? any_but_space()
                                                         : 8'(CH_A + $urandom_range(0, 7)));
         // leave off the rank now and then
         if ($urandom_range(0, 9) != 0)
            line_buf.push_back(($urandom_range(0, 9) == 0) ? any_but_space()
                                                            : 8'(CH_ONE + $urandom_range(0, 7)));
      end
      if ($urandom_range(0, 1) == 0) begin
         line_buf.push_back(CH_SPACE);
         line_buf.push_back(8'(CH_ONE + $urandom_range(0, 7)));
         line_buf.push_back(CH_SPACE);
         line_buf.push_back(8'(CH_ONE + $urandom_range(0, 7)));
      end
      // cut the string short in some phase
      if ($urandom_range(0, 6) == 0) begin
         len = $urandom_range(1, line_buf.size());
         while (line_buf.size() > len) void'(line_buf.pop_back());
      end
   endfunction

   function automatic void make_noise();
      line_buf.delete();
      repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
   endfunction

   task automatic send_text();
      int gap_pct;
      case ($urandom_range(0, 2))
         0: gap_pct = 0;
         1: gap_pct = 15;
         default: gap_pct = 40;
      endcase
      for (int i = 0; i < line_buf.size(); i++) begin
         if (!calm && $urandom_range(1, 100) <= gap_pct) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat ($urandom_range(0, 11)) @(negedge clock);
         end
         @(negedge clock);
         req_valid         <= 1'b1;
         req_char_in       <= line_buf[i];
         req_end_of_string <= (i == line_buf.size() - 1);
         do @(posedge clock); while (!req_ready);
         sb.note_char(line_buf[i], i == line_buf.size() - 1);
         chars_sent++;
      end
      strings_sent++;
   endtask

   initial begin
      int stall_left;
      int stall_pct;
      int span;
      rsp_ready  = 1'b0;
      stall_left = 0;
      stall_pct  = 0;
      span       = 0;
      forever begin
         @(negedge clock);
         if (span == 0) begin
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 10;
               default: stall_pct = 35;
            endcase
            span = 64;
         end
         span--;
         if (calm) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(1, 100) <= stall_pct) begin
            stall_left = $urandom_range(0, 11);
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_board('{rsp_board_index, rsp_board_value, rsp_white_to_move,
                          rsp_castle_rights, rsp_ep_valid, rsp_ep_file,
                          rsp_ep_rank, rsp_last_board});
   end

   initial begin
      int random_chars;
      req_valid         = 1'b0;
      req_char_in       = '0;
      req_end_of_string = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // off-board pieces, castling, en passant with a real square
      line_buf.delete();
      load_text("f Kk7/8p w Kq e3");
      send_text();
      // skip characters 9, 0 and 0xFF, then end right on the side letter
      line_buf.delete();
      load_text("x 9");
      line_buf.push_back(8'hFF);
      load_text("0/ b");
      send_text();
      // end in the leading word; side to move must stay black
      line_buf.delete();
      line_buf.push_back(8'h00);
      send_text();

      random_chars = 0;
      while (random_chars < 200) begin
         if ($urandom_range(0, 9) == 0) make_noise();
         else make_position();
         calm = (random_chars >= 160);
         random_chars += line_buf.size();
         send_text();
      end

      @(negedge clock);
      req_valid         <= 1'b0;
      req_end_of_string <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("Parsed %0d position strings (%0d characters) and compared %0d boards.",
               strings_sent, chars_sent, sb.boards_seen);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #400_000;
      $display("Timeout with %0d boards still owed", sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/fpp_pkg.sv
hw/rtl/fpp_front.sv
hw/rtl/fpp_queue.sv
hw/rtl/fpp_back.sv
hw/rtl/fen_position_parser_top.sv
dv/tb.sv
